### hdl/vae_pkg.sv
package vae_pkg;

  localparam int SymW       = 16;
  localparam int AlphaDepth = 64;
  localparam int AlphaW     = $clog2(AlphaDepth);
  localparam int NW         = AlphaW + 1;
  localparam int KeyDepth   = 64;
  localparam int KeyW       = $clog2(KeyDepth);
  localparam int KsW        = KeyW + 1;
  localparam int CfgW       = 7;
  localparam int CfgIdxW    = 1;

  localparam logic [CfgW-1:0] AlphaSizeRst = CfgW'(33);
  localparam logic [CfgW-1:0] KeySizeRst   = CfgW'(1);

  localparam logic [CfgIdxW-1:0] CFG_ALPHA_SIZE = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_KEY_SIZE   = CfgIdxW'(1);

  typedef enum logic [1:0] {
    OP_ALPHA_WR = 2'd0,
    OP_KEY_WR   = 2'd1,
    OP_ENCRYPT  = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  // token handed from cell to cell along the chain
  typedef struct packed {
    logic              valid;
    logic              fetch;
    logic [AlphaW-1:0] pos;
    logic [SymW-1:0]   pt_sym;
    logic [SymW-1:0]   key_sym;
    logic              pt_hit;
    logic [AlphaW-1:0] pt_pos;
    logic              key_hit;
    logic [AlphaW-1:0] key_pos;
    logic [AlphaW-1:0] target;
    logic [SymW-1:0]   data;
  } tok_t;

endpackage

### hdl/vigenere_alphabet_encryptor.sv
// channel  direction  handshake               payload
// in       input      in_valid_i/in_ready_o   op_i index_i symbol_i message_start_i
// out      output     out_valid_o/out_ready_i out_symbol_o passed_through_o
// cfg      input      cfg_we_i                cfg_index_i cfg_data_i
//
// Table writes and unused ops complete on their accept; the block stays ready.
// An encrypt, from its accept to the next accept, does one key memory read, then a token
// walks the 64-cell alphabet chain once to find both positions and once more to fetch the
// result; a plaintext symbol not in the alphabet passes through after the first walk.
// A found plaintext but missing key symbol ends after the first walk with no item out.
// One item is in flight at a time; a finished result waits until the output register is free.
// No clearing pass after reset; the block is ready as soon as rst_ni rises.
module vigenere_alphabet_encryptor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [5:0]                    index_i,
  input  logic [15:0]                   symbol_i,
  input  logic                          message_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   out_symbol_o,
  output logic                          passed_through_o,
  input  logic                          cfg_we_i,
  input  logic [vae_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vae_pkg::CfgW-1:0]      cfg_data_i
);
  import vae_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_KEY    = 5'b00010,
    S_SEARCH = 5'b00100,
    S_FETCH  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e state_d, state_q;

  logic [CfgW-1:0] alpha_size_q, key_size_q;
  logic [NW-1:0]   alpha_n;
  logic [KsW-1:0]  key_n;

  logic [SymW-1:0] key_mem [KeyDepth];
  logic [SymW-1:0] key_rd_q;
  logic [KeyW-1:0] key_rd_addr;

  logic [KeyW-1:0] key_pos_d, key_pos_q;
  logic [KeyW-1:0] kp_start;
  logic [KsW-1:0]  kp_next;
  logic [KeyW-1:0] kp_adv;

  logic [SymW-1:0] sym_d, sym_q;
  tok_t            head_d, head_q;
  tok_t            chain [AlphaDepth+1];
  tok_t            tail;

  logic [NW-1:0]     sum_raw;
  logic [AlphaW-1:0] sum;

  logic            res_pass_d, res_pass_q;
  logic [SymW-1:0] res_sym_d, res_sym_q;

  logic            out_valid_q, out_pass_q;
  logic [SymW-1:0] out_sym_q;
  logic            out_load;

  logic            accept;
  op_e             op;

  assign accept = in_valid_i && in_ready_o;
  assign op     = op_e'(op_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_size_q <= AlphaSizeRst;
      key_size_q   <= KeySizeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ALPHA_SIZE: alpha_size_q <= cfg_data_i;
        CFG_KEY_SIZE:   key_size_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign alpha_n = (alpha_size_q > CfgW'(AlphaDepth)) ? NW'(AlphaDepth) : NW'(alpha_size_q);

  always_comb begin
    if (key_size_q == '0) begin
      key_n = KsW'(1);
    end else if (key_size_q > CfgW'(KeyDepth)) begin
      key_n = KsW'(KeyDepth);
    end else begin
      key_n = KsW'(key_size_q);
    end
  end

  // key position for this encrypt, wrapped if key_size was lowered
  always_comb begin
    kp_start = message_start_i ? '0 : key_pos_q;
    if ({1'b0, kp_start} >= key_n) begin
      kp_start = '0;
    end
  end

  assign key_rd_addr = kp_start;
  assign kp_next     = {1'b0, key_pos_q} + KsW'(1);
  assign kp_adv      = (kp_next >= key_n) ? '0 : kp_next[KeyW-1:0];

  // key store
  always_ff @(posedge clk_i) begin
    if (accept && op == OP_KEY_WR) begin
      key_mem[index_i] <= symbol_i;
    end
    key_rd_q <= key_mem[key_rd_addr];
  end

  // alphabet chain
  assign chain[0] = head_q;

  for (genvar i = 0; i < AlphaDepth; i++) begin : g_cell
    logic wr_en;
    assign wr_en = accept && op == OP_ALPHA_WR && index_i == AlphaW'(i);
    vae_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .alpha_n_i (alpha_n),
      .wr_en_i   (wr_en),
      .wr_data_i (symbol_i),
      .tok_i     (chain[i]),
      .tok_o     (chain[i+1])
    );
  end

  assign tail = chain[AlphaDepth];

  assign sum_raw = {1'b0, tail.pt_pos} + {1'b0, tail.key_pos};
  assign sum     = (sum_raw >= alpha_n) ? AlphaW'(sum_raw - alpha_n) : sum_raw[AlphaW-1:0];

  assign out_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    key_pos_d  = key_pos_q;
    sym_d      = sym_q;
    head_d     = '0;
    res_pass_d = res_pass_q;
    res_sym_d  = res_sym_q;
    case (state_q)
      S_IDLE: begin
        if (accept && op == OP_ENCRYPT) begin
          key_pos_d = kp_start;
          sym_d     = symbol_i;
          state_d   = S_KEY;
        end
      end
      S_KEY: begin
        head_d.valid   = 1'b1;
        head_d.pt_sym  = sym_q;
        head_d.key_sym = key_rd_q;
        state_d        = S_SEARCH;
      end
      S_SEARCH: begin
        if (tail.valid) begin
          if (!tail.pt_hit) begin
            res_pass_d = 1'b1;
            res_sym_d  = sym_q;
            state_d    = S_EMIT;
          end else begin
            key_pos_d = kp_adv;
            if (!tail.key_hit) begin
              // key symbol missing from the alphabet: nothing goes out
              state_d = S_IDLE;
            end else begin
              head_d.valid  = 1'b1;
              head_d.fetch  = 1'b1;
              head_d.target = sum;
              state_d       = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        if (tail.valid) begin
          res_pass_d = 1'b0;
          res_sym_d  = tail.data;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      key_pos_q <= '0;
      head_q    <= '0;
    end else begin
      state_q   <= state_d;
      key_pos_q <= key_pos_d;
      head_q    <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    res_pass_q <= res_pass_d;
    res_sym_q  <= res_sym_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_load) begin
      out_sym_q  <= res_sym_q;
      out_pass_q <= res_pass_q;
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign out_symbol_o     = out_sym_q;
  assign passed_through_o = out_pass_q;

endmodule

### hdl/vae_cell.sv
module vae_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [vae_pkg::NW-1:0]     alpha_n_i,
  input  logic                       wr_en_i,
  input  logic [vae_pkg::SymW-1:0]   wr_data_i,
  input  vae_pkg::tok_t              tok_i,
  output vae_pkg::tok_t              tok_o
);
  import vae_pkg::*;

  logic [SymW-1:0] entry_q;
  tok_t            tok_d, tok_q;
  logic            in_use;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_data_i;
    end
  end

  assign in_use = ({1'b0, tok_i.pos} < alpha_n_i);

  always_comb begin
    tok_d     = tok_i;
    tok_d.pos = tok_i.pos + AlphaW'(1);
    if (!tok_i.fetch) begin
      // first match wins, later cells leave the position alone
      if (in_use && !tok_i.pt_hit && entry_q == tok_i.pt_sym) begin
        tok_d.pt_hit = 1'b1;
        tok_d.pt_pos = tok_i.pos;
      end
      if (in_use && !tok_i.key_hit && entry_q == tok_i.key_sym) begin
        tok_d.key_hit = 1'b1;
        tok_d.key_pos = tok_i.pos;
      end
    end else if (tok_i.pos == tok_i.target) begin
      tok_d.data = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
